@@ rtl/wsa_pkg.sv @@
// Shared types and codes for the weighted sparse aggregation core.
package wsa_pkg;

    // Input action codes.
    localparam logic [2:0] ACT_FEATURE  = 3'd0;
    localparam logic [2:0] ACT_WEIGHT   = 3'd1;
    localparam logic [2:0] ACT_BIAS     = 3'd2;
    localparam logic [2:0] ACT_ROW      = 3'd3;
    localparam logic [2:0] ACT_NEIGHBOR = 3'd4;
    localparam logic [2:0] ACT_COMPUTE  = 3'd5;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RS0,
        S_RS1,
        S_CHK,
        S_NB,
        S_OP,
        S_MUL,
        S_ACC,
        S_BIAS,
        S_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic idle;
        logic capture;
        logic rd_row_lo;
        logic rd_row_hi;
        logic nb_rd;
        logic op_rd;
        logic mul;
        logic acc;
        logic bias_add;
        logic out;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic req_ok;
        logic more;
        logic use_bias;
    } t_dp_stat;

endpackage

@@ rtl/wsa_ctrl.sv @@
// Sequencing state machine for the weighted sparse aggregation core.
module wsa_ctrl
    import wsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_stat.req_ok) n_state = S_RS0;
            end
            S_RS0: n_state = S_RS1;
            S_RS1: n_state = S_CHK;
            S_CHK: begin
                if (i_stat.more)          n_state = S_NB;
                else if (i_stat.use_bias) n_state = S_BIAS;
                else                      n_state = S_OUT;
            end
            S_NB:   n_state = S_OP;
            S_OP:   n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = S_CHK;
            S_BIAS: n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Command decode.
    always_comb begin
        o_cmd           = '0;
        o_cmd.idle      = (r_state == S_IDLE);
        o_cmd.capture   = (r_state == S_IDLE) && i_start;
        o_cmd.rd_row_lo = (r_state == S_RS0);
        o_cmd.rd_row_hi = (r_state == S_RS1);
        o_cmd.nb_rd     = (r_state == S_NB);
        o_cmd.op_rd     = (r_state == S_OP);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.bias_add  = (r_state == S_BIAS);
        o_cmd.out       = (r_state == S_OUT);
        o_busy          = (r_state != S_IDLE);
    end

`ifndef ASSERT_OFF
    // A result strobe lasts one cycle and then the block is free.
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_state == S_IDLE))
        else $error("result strobe longer than one cycle");
    // Work starts only from an accepted valid compute request.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RS0) |-> $past(i_start && i_stat.req_ok))
        else $error("compute started without request");
    // The bias stage is entered only when bias is enabled.
    a_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIAS) |-> $past(i_stat.use_bias))
        else $error("bias stage without bias enabled");
`endif

endmodule

@@ rtl/wsa_dp.sv @@
// Stores, multiply-accumulate and result registers of the aggregation core.
module wsa_dp
    import wsa_pkg::*;
#(
    parameter int VERTICES     = 256,
    parameter int FEATURE_DIMS = 16,
    parameter int EDGES        = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_start,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic [2:0]         i_action,
    input  logic [10:0]        i_index,
    input  logic [3:0]         i_dim,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_source_vertex,
    input  logic [9:0]         i_edge_id,
    output logic signed [31:0] o_sum_value,
    output logic [7:0]         o_result_vertex,
    output logic [3:0]         o_result_dim,
    output logic               o_overflow
);

    localparam int VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int DW  = (FEATURE_DIMS > 1) ? $clog2(FEATURE_DIMS) : 1;
    localparam int EW  = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int RAW = $clog2(VERTICES + 1);
    localparam int RW  = $clog2(EDGES + 1);
    localparam int FD  = VERTICES * FEATURE_DIMS;
    localparam int FA  = (FD > 1) ? $clog2(FD) : 1;

    localparam logic signed [49:0] Q_MAX = 50'sd2147483647;
    localparam logic signed [49:0] Q_MIN = -50'sd2147483648;

    // Memories.
    logic signed [31:0] feat_mem [FD];
    logic signed [31:0] wt_mem   [EDGES];
    logic signed [31:0] bias_mem [VERTICES];
    logic [RW-1:0]      row_mem  [VERTICES + 1];
    logic [7:0]         src_mem  [EDGES];
    logic [9:0]         eid_mem  [EDGES];

    logic               r_use_bias;
    logic [VW-1:0]      r_idx;
    logic [DW-1:0]      r_dim;
    logic [RW-1:0]      r_row_q;
    logic [RW-1:0]      r_ptr;
    logic signed [31:0] r_bias_q;
    logic [7:0]         r_src_q;
    logic [9:0]         r_eid_q;
    logic               r_ok;
    logic signed [31:0] r_feat_q;
    logic signed [31:0] r_wt_q;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_acc;
    logic               r_ovf;

    logic               ld;
    logic               idx_v_ok;
    logic [RW-1:0]      row_val;
    logic [RAW-1:0]     row_addr;
    logic               nb_ok;
    logic [FA-1:0]      feat_addr;
    logic signed [63:0] prod_rnd;
    logic signed [49:0] add_term;
    logic signed [49:0] sum;

    // Request decode and range checks.
    assign ld       = i_cmd.idle && i_start;
    assign idx_v_ok = 32'(i_index) < VERTICES;

    always_comb begin
        if (i_value < 0)
            row_val = '0;
        else if (i_value > 32'sd0 + EDGES)
            row_val = RW'(EDGES);
        else
            row_val = RW'(i_value);
    end

    assign o_stat.req_ok   = (i_action == ACT_COMPUTE) && idx_v_ok &&
                             (32'(i_dim) < FEATURE_DIMS);
    assign o_stat.more     = r_ptr < r_row_q;
    assign o_stat.use_bias = r_use_bias;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_bias <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_use_bias <= i_cfg_wr_data;
        end
    end

    // Store writes from load transfers.
    always_ff @(posedge i_clk) begin
        if (ld && i_action == ACT_FEATURE && idx_v_ok && 32'(i_dim) < FEATURE_DIMS) begin
            feat_mem[FA'(32'(i_dim) * VERTICES + 32'(i_index))] <= i_value;
        end
        if (ld && i_action == ACT_WEIGHT && 32'(i_index) < EDGES) begin
            wt_mem[EW'(i_index)] <= i_value;
        end
        if (ld && i_action == ACT_BIAS && idx_v_ok) begin
            bias_mem[VW'(i_index)] <= i_value;
        end
        if (ld && i_action == ACT_ROW && 32'(i_index) <= VERTICES) begin
            row_mem[RAW'(i_index)] <= row_val;
        end
        if (ld && i_action == ACT_NEIGHBOR && 32'(i_index) < EDGES) begin
            src_mem[EW'(i_index)] <= i_source_vertex;
            eid_mem[EW'(i_index)] <= i_edge_id;
        end
    end

    // Row bounds and bias reads.
    assign row_addr = i_cmd.rd_row_hi ? (RAW'(r_idx) + RAW'(1)) : RAW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= VW'(i_index);
            r_dim <= DW'(i_dim);
        end
        if (i_cmd.rd_row_lo || i_cmd.rd_row_hi) begin
            r_row_q <= row_mem[row_addr];
        end
        if (i_cmd.rd_row_lo) begin
            r_bias_q <= bias_mem[r_idx];
        end
    end

    // Neighbor walk pointer and entry read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_row_hi) begin
            r_ptr <= r_row_q;
        end else if (i_cmd.nb_rd) begin
            r_ptr <= r_ptr + RW'(1);
        end
        if (i_cmd.nb_rd) begin
            r_src_q <= src_mem[EW'(r_ptr)];
            r_eid_q <= eid_mem[EW'(r_ptr)];
        end
    end

    // Operand reads for one neighbor.
    assign nb_ok     = (32'(r_src_q) < VERTICES) && (32'(r_eid_q) < EDGES);
    assign feat_addr = FA'(32'(r_dim) * VERTICES + 32'(r_src_q));

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_rd) begin
            r_ok     <= nb_ok;
            r_feat_q <= feat_mem[feat_addr];
            r_wt_q   <= wt_mem[EW'(r_eid_q)];
        end
        if (i_cmd.mul) begin
            r_prod <= r_feat_q * r_wt_q;
        end
    end

    // Rounded product and saturating add.
    assign prod_rnd = (r_prod + 64'sd32768) >>> 16;
    assign add_term = i_cmd.bias_add ? 50'(r_bias_q) : 50'(prod_rnd);
    assign sum      = 50'(r_acc) + add_term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if ((i_cmd.acc && r_ok) || i_cmd.bias_add) begin
            if (sum > Q_MAX) begin
                r_acc <= 32'sh7fffffff;
                r_ovf <= 1'b1;
            end else if (sum < Q_MIN) begin
                r_acc <= 32'sh80000000;
                r_ovf <= 1'b1;
            end else begin
                r_acc <= 32'(sum);
            end
        end
    end

    // Result fields.
    assign o_sum_value     = r_acc;
    assign o_result_vertex = 8'(r_idx);
    assign o_result_dim    = 4'(r_dim);
    assign o_overflow      = r_ovf & i_cmd.out | r_ovf;

endmodule

@@ rtl/weighted_sparse_aggregate_core.sv @@
// Top level of the weighted sparse aggregation core.
//
// Channel   Ports                                          Transfer
// command   i_start, o_busy, i_action .. i_edge_id         i_start high and o_busy low
// result    o_valid, o_sum_value .. o_overflow             o_valid high, one cycle
// config    i_cfg_wr_en, i_cfg_wr_data                     i_cfg_wr_en high
//
// Load commands complete in the cycle they are taken and never raise o_busy.
// A compute command reads the row bounds, walks each neighbor and adds the bias when bias is enabled;
// each neighbor walks entry read, operand read, multiply and accumulate.
// Reset is synchronous and active low; the stores are not cleared.
// The result is shown for one cycle and the receiver cannot stall it.
module weighted_sparse_aggregate_core
    import wsa_pkg::*;
#(
    parameter int VERTICES     = 256,
    parameter int FEATURE_DIMS = 16,
    parameter int EDGES        = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_action,
    input  logic [10:0]        i_index,
    input  logic [3:0]         i_dim,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_source_vertex,
    input  logic [9:0]         i_edge_id,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    output logic               o_valid,
    output logic signed [31:0] o_sum_value,
    output logic [7:0]         o_result_vertex,
    output logic [3:0]         o_result_dim,
    output logic               o_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    wsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Datapath and stores.
    wsa_dp #(
        .VERTICES     (VERTICES),
        .FEATURE_DIMS (FEATURE_DIMS),
        .EDGES        (EDGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_start         (i_start),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_action        (i_action),
        .i_index         (i_index),
        .i_dim           (i_dim),
        .i_value         (i_value),
        .i_source_vertex (i_source_vertex),
        .i_edge_id       (i_edge_id),
        .o_sum_value     (o_sum_value),
        .o_result_vertex (o_result_vertex),
        .o_result_dim    (o_result_dim),
        .o_overflow      (o_overflow)
    );

    // The result strobe comes from the output state.
    assign o_valid = cmd.out;

endmodule
